>>> sv/rlte_pkg.sv
// Shared types and constants for the run length text encoder.
`default_nettype none
package rlte_pkg;

  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned NUM_DIGITS  = 5;
  localparam int unsigned ND_W        = 3;

  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef struct packed {
    logic [7:0] symbol;
    logic       stream_end;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       burst_last;
    logic       encoding_end;
  } result_t;

  // one finished run, handed from the front to the back
  typedef struct packed {
    logic [7:0]         symbol;
    logic [COUNT_W-1:0] count;
    logic               burst_last;
    logic               encoding_end;
  } run_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

>>> sv/rlte_queue.sv
// Short command queue between the front and the back.
`default_nettype none
module rlte_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rlte_pkg::run_cmd_t din,
  output logic                   full,
  input  wire logic              pop,
  output rlte_pkg::run_cmd_t     dout,
  output logic                   empty
);
  import rlte_pkg::*;

  run_cmd_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  logic do_push;
  logic do_pop;

  assign full    = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/rlte_front.sv
// Front end: tracks the open run and issues a command for each finished run.
`default_nettype none
module rlte_front #(
  parameter int unsigned MAX_RUN = 65535
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rlte_pkg::item_t   item,
  output logic                   full,
  output logic                   cmd_push,
  output rlte_pkg::run_cmd_t     cmd,
  input  wire logic              cmd_full
);
  import rlte_pkg::*;

  logic [7:0]         run_symbol;
  logic [COUNT_W-1:0] run_count;
  logic               run_open;
  logic               pend_valid;
  run_cmd_t           pend_cmd;

  logic               accept;
  logic               diff_close;
  logic               new_close;
  logic [COUNT_W:0]   new_count;
  run_cmd_t           old_cmd;
  run_cmd_t           new_cmd;

  assign full   = pend_valid || cmd_full;
  assign accept = push && !full;

  always_comb begin
    diff_close = run_open && (item.symbol != run_symbol);
    if (!run_open || diff_close) begin
      new_count = (COUNT_W+1)'(1);
    end else begin
      new_count = {1'b0, run_count} + 1'b1;
    end
    new_close = (new_count >= (COUNT_W+1)'(MAX_RUN)) || item.stream_end;

    old_cmd.symbol       = run_symbol;
    old_cmd.count        = run_count;
    old_cmd.burst_last   = !new_close;
    old_cmd.encoding_end = 1'b0;

    new_cmd.symbol       = item.symbol;
    new_cmd.count        = new_count[COUNT_W-1:0];
    new_cmd.burst_last   = 1'b1;
    new_cmd.encoding_end = item.stream_end;

    // a stalled second command goes first; the input is blocked meanwhile
    cmd_push = 1'b0;
    cmd      = pend_cmd;
    if (pend_valid) begin
      cmd_push = !cmd_full;
    end else if (accept) begin
      cmd_push = diff_close || new_close;
      cmd      = diff_close ? old_cmd : new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && diff_close && new_close) begin
      pend_cmd <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_symbol <= '0;
      run_count  <= '0;
      run_open   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && !cmd_full) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        pend_valid <= diff_close && new_close;
        run_symbol <= item.symbol;
        if (new_close) begin
          run_open  <= 1'b0;
          run_count <= '0;
        end else begin
          run_open  <= 1'b1;
          run_count <= new_count[COUNT_W-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/rlte_back.sv
// Back end: writes each run as its symbol and decimal count into the output register.
`default_nettype none
module rlte_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rlte_pkg::run_cmd_t cmd,
  input  wire logic              cmd_empty,
  output logic                   cmd_pop,
  output rlte_pkg::result_t      result,
  output logic                   empty,
  input  wire logic              pop
);
  import rlte_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] rem_next;
  logic [3:0]         digits      [NUM_DIGITS];
  logic [3:0]         digits_next [NUM_DIGITS];
  logic [ND_W-1:0]    nd;
  logic [ND_W-1:0]    nd_next;
  logic               run_last;
  logic               run_last_next;
  logic               run_end;
  logic               run_end_next;
  logic               out_valid;
  result_t            out_data;
  result_t            out_data_next;
  logic               load_out;

  logic               slot_free;
  logic [COUNT_W-1:0] div_in;
  logic [31:0]        prod;
  logic [COUNT_W-1:0] quo;
  logic [COUNT_W-1:0] quo_x10;
  logic [3:0]         rdig;
  logic [ND_W-1:0]    rd_idx;

  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;
  assign result    = out_data;

  // divide by ten: reciprocal multiply, then back out the remainder
  always_comb begin
    div_in  = (state == BK_IDLE) ? cmd.count : rem;
    prod    = 32'(div_in) * 32'(DIV10_MUL);
    quo     = COUNT_W'(prod >> DIV10_SHIFT);
    quo_x10 = (quo << 3) + (quo << 1);
    rdig    = 4'(div_in - quo_x10);
    rd_idx  = nd - 1'b1;
  end

  always_comb begin
    state_next    = state;
    rem_next      = rem;
    nd_next       = nd;
    digits_next   = digits;
    run_last_next = run_last;
    run_end_next  = run_end;
    out_data_next = out_data;
    load_out      = 1'b0;
    cmd_pop       = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!cmd_empty && slot_free) begin
          cmd_pop                    = 1'b1;
          load_out                   = 1'b1;
          out_data_next.out_byte     = cmd.symbol;
          out_data_next.burst_last   = 1'b0;
          out_data_next.encoding_end = 1'b0;
          digits_next[0]             = rdig;
          nd_next                    = ND_W'(1);
          rem_next                   = quo;
          run_last_next              = cmd.burst_last;
          run_end_next               = cmd.encoding_end;
          state_next                 = (quo == '0) ? BK_EMIT : BK_CONV;
        end
      end
      BK_CONV: begin
        digits_next[nd] = rdig;
        nd_next         = nd + 1'b1;
        rem_next        = quo;
        if (quo == '0) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        // digits were collected least significant first; send from the top
        if (slot_free) begin
          load_out                   = 1'b1;
          out_data_next.out_byte     = ASCII_ZERO + {4'd0, digits[rd_idx]};
          out_data_next.burst_last   = (rd_idx == '0) && run_last;
          out_data_next.encoding_end = (rd_idx == '0) && run_end;
          nd_next                    = rd_idx;
          if (rd_idx == '0) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rem      <= rem_next;
    digits   <= digits_next;
    run_last <= run_last_next;
    run_end  <= run_end_next;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nd        <= '0;
      out_valid <= 1'b0;
    end else begin
      nd <= nd_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/run_length_text_encoder.sv
// Top level of the run length text encoder.
`default_nettype none
// Byte stream in, text run-length code out: each run leaves as its symbol byte and then
// its length in ASCII decimal, most significant digit first. The front takes one byte per
// cycle while its command queue has room and no second command is pending, and closes a
// run on a new symbol, on a byte flagged stream_end, or when the run reaches MAX_RUN.
// The back turns a run with a d-digit length into d+1 result bytes: the symbol goes out
// while the first digit is split off, the divide-by-ten unit then splits off each further
// digit, and the digits are sent one by one through the single output register. A byte
// that closes two runs holds the input until its second command has entered the queue.
module run_length_text_encoder #(
  parameter int unsigned MAX_RUN = 65535
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire rlte_pkg::item_t   item,
  output logic                   empty,
  input  wire logic              pop,
  output rlte_pkg::result_t      result
);
  import rlte_pkg::*;

  logic     f_push;
  run_cmd_t f_cmd;
  logic     q_full;
  logic     q_pop;
  run_cmd_t q_cmd;
  logic     q_empty;

  rlte_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_push (f_push),
    .cmd      (f_cmd),
    .cmd_full (q_full)
  );

  rlte_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_cmd),
    .empty (q_empty)
  );

  rlte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire

>>> verif/run_length_text_encoder_test.sv
// Self-checking testbench for the run length text encoder: directed runs and random streams.
`default_nettype none
module run_length_text_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlte_pkg::*;

  localparam int unsigned RUN_LIMIT  = 65535;
  localparam int unsigned WATCHDOG   = 4000;
  localparam int unsigned TAIL_WAIT  = 40;
  localparam int unsigned RAND_ITEMS = 165;

  // Expected encoder output, built byte by byte from the accepted input stream.
  class rle_scoreboard;
    result_t     want_q[$];
    logic [7:0]  run_sym;
    logic [15:0] run_len;
    bit          run_live;
    int unsigned max_run;
    int unsigned errors;
    int unsigned bytes_in;
    int unsigned bytes_out;
    int unsigned streams;
    int unsigned longest;

    function new(int unsigned limit);
      max_run   = limit;
      run_sym   = '0;
      run_len   = '0;
      run_live  = 1'b0;
      errors    = 0;
      bytes_in  = 0;
      bytes_out = 0;
      streams   = 0;
      longest   = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Close the open run: symbol first, then decimal length, most significant digit first.
    function void close_run();
      logic [7:0]  digit[5];
      int          nd;
      int unsigned c;
      result_t     r;
      nd = 0;
      c  = run_len;
      if (run_len > longest) longest = run_len;
      do begin
        digit[nd] = ASCII_ZERO + 8'(c % 10);
        nd++;
        c = c / 10;
      end while (c != 0 && nd < 5);
      r.out_byte     = run_sym;
      r.burst_last   = 1'b0;
      r.encoding_end = 1'b0;
      want_q.push_back(r);
      while (nd > 0) begin
        nd--;
        r.out_byte = digit[nd];
        want_q.push_back(r);
      end
      run_live = 1'b0;
      run_len  = '0;
    endfunction

    function void note_item(item_t it);
      int      size_prior;
      result_t r;
      size_prior = want_q.size();
      bytes_in++;
      if (it.stream_end) streams++;
      if (run_live && it.symbol != run_sym) close_run();
      if (!run_live) begin
        run_sym  = it.symbol;
        run_len  = 16'd1;
        run_live = 1'b1;
      end else begin
        run_len = run_len + 16'd1;
      end
      if (run_len >= max_run || it.stream_end) close_run();
      // flag the tail of this transaction's burst
      if (want_q.size() > size_prior) begin
        r = want_q.pop_back();
        r.burst_last   = 1'b1;
        r.encoding_end = it.stream_end;
        want_q.push_back(r);
      end
    endfunction

    task check_result(result_t got);
      result_t want;
      bytes_out++;
      if (want_q.size() == 0) begin
        report($sformatf("unexpected byte %h (last %b, end %b)",
                         got.out_byte, got.burst_last, got.encoding_end));
      end else begin
        want = want_q.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
        if (got.burst_last !== want.burst_last)
          report($sformatf("burst_last %b, want %b on byte %h",
                           got.burst_last, want.burst_last, want.out_byte));
        if (got.encoding_end !== want.encoding_end)
          report($sformatf("encoding_end %b, want %b on byte %h",
                           got.encoding_end, want.encoding_end, want.out_byte));
      end
    endtask
  endclass

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;

  rle_scoreboard sb = new(RUN_LIMIT);
  bit            send_idle;
  bit            recv_idle;
  int unsigned   quiet_cycles;

  run_length_text_encoder #(.MAX_RUN(RUN_LIMIT)) uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Monitor both handshakes and guard against a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_item(item);
      if (pop && !empty) sb.check_result(result);
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG);
        $display("run_length_text_encoder_test: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: stall pop at random while recv_idle is set.
  initial begin
    int unsigned hold;
    hold = 0;
    pop  = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_idle && hold == 0 && $urandom_range(0, 3) == 0) hold = pick_gap();
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] sym, input logic fin);
    int unsigned gap;
    item_t       it;
    item_t       junk;
    gap           = send_idle ? pick_gap() : 0;
    it.symbol     = sym;
    it.stream_end = fin;
    if (gap > 0) begin
      junk.symbol     = 8'($urandom);
      junk.stream_end = 1'($urandom);
      @(negedge clk);
      push <= 1'b0;
      item <= junk;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_run(input logic [7:0] sym, input int unsigned len, input bit close);
    for (int unsigned i = 0; i < len; i++) send_byte(sym, close && i == len - 1);
  endtask

  // Hold the input until every expected byte has come out.
  task automatic drain_encoder();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Well-formed streams of random runs, with a stray stream_end now and then.
  task automatic random_streams(input int unsigned budget);
    int unsigned sent;
    int unsigned nruns;
    int unsigned len;
    int unsigned r;
    logic [7:0]  sym;
    logic [7:0]  alpha[3];
    bit          fin;
    sent = 0;
    while (sent < budget) begin
      for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom);
      nruns = $urandom_range(1, 6);
      for (int unsigned n = 0; n < nruns; n++) begin
        sym = ($urandom_range(0, 9) < 7) ? alpha[$urandom_range(0, 2)] : 8'($urandom);
        r   = $urandom_range(0, 99);
        len = (r < 70) ? $urandom_range(1, 3) : (r < 95) ? $urandom_range(4, 12)
                                                         : $urandom_range(13, 40);
        for (int unsigned i = 0; i < len; i++) begin
          fin = (n == nruns - 1 && i == len - 1) || ($urandom_range(0, 39) == 0);
          send_byte(sym, fin);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    push         = 1'b0;
    item         = '0;
    quiet_cycles = 0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero symbol right after reset, then the other extreme
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // alternating single bytes
    send_byte("A", 1'b0);
    send_byte("B", 1'b0);
    send_byte("A", 1'b1);
    // a run closed by a new final byte
    send_run("x", 2, 1'b0);
    send_byte("y", 1'b1);
    // final byte extends the run
    send_run("z", 2, 1'b1);
    // same symbol across a stream boundary starts afresh
    send_byte("q", 1'b1);
    send_byte("q", 1'b1);
    send_run("n", 3, 1'b0);
    send_run("p", 2, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    drain_encoder();

    // one-to-two digit boundary, back to back on the input
    send_idle = 1'b0;
    send_run("a", 9, 1'b1);
    send_run("b", 10, 1'b1);
    send_run("k", 12, 1'b0);
    send_byte("m", 1'b1);
    drain_encoder();

    send_idle = 1'b1;
    recv_idle = 1'b1;
    random_streams(RAND_ITEMS / 3);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    random_streams(RAND_ITEMS / 3);
    drain_encoder();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    random_streams(RAND_ITEMS / 3);

    drain_encoder();
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d bytes never came out", sb.pending()));

    $display("covered %0d input bytes in %0d streams, %0d output bytes checked",
             sb.bytes_in, sb.streams, sb.bytes_out);
    $display("longest run emitted %0d, run limit %0d, %0d mismatches",
             sb.longest, RUN_LIMIT, sb.errors);
    if (sb.errors == 0) begin
      $display("run_length_text_encoder_test: clean");
    end else begin
      $display("run_length_text_encoder_test: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
